### hdl/edtpc_pkg.sv
`timescale 1ns / 1ps
package edtpc_pkg;

  localparam int unsigned DivW = 64;
  localparam int unsigned DsrW = 34;
  localparam int unsigned CntW = 6;
  localparam logic [29:0] NsPerSec = 30'd1000000000;

  // Request from the sequencer to the shared divider.
  typedef struct packed {
    logic            start;
    logic [CntW-1:0] iters;
  } div_req_t;

  // Sequencer states, one-hot.
  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_MUL  = 10'b0000000010,
    ST_DST  = 10'b0000000100,
    ST_DIV  = 10'b0000001000,
    ST_CMP  = 10'b0000010000,
    ST_CD1  = 10'b0000100000,
    ST_CD2  = 10'b0001000000,
    ST_LAW  = 10'b0010000000,
    ST_LDIV = 10'b0100000000,
    ST_DONE = 10'b1000000000
  } state_e;

  // Configuration register indexes.
  localparam logic [3:0] RegRate     = 4'd0;
  localparam logic [3:0] RegOverhead = 4'd1;
  localparam logic [3:0] RegMinFrame = 4'd2;
  localparam logic [3:0] RegIdleMin  = 4'd3;
  localparam logic [3:0] RegDropHor  = 4'd4;
  localparam logic [3:0] RegTarget   = 4'd5;
  localparam logic [3:0] RegEcnHor   = 4'd6;
  localparam logic [3:0] RegInterval = 4'd7;

  // Square root of the drop count, scaled by 2^16; sqrt(32) outside one to sixteen.
  function automatic logic [18:0] sqrt_sh16(input logic [31:0] cnt);
    logic [18:0] s;
    begin
      unique case (cnt)
        32'd1:   s = 19'd65536;
        32'd2:   s = 19'd92682;
        32'd3:   s = 19'd113512;
        32'd4:   s = 19'd131072;
        32'd5:   s = 19'd146543;
        32'd6:   s = 19'd160530;
        32'd7:   s = 19'd173392;
        32'd8:   s = 19'd185364;
        32'd9:   s = 19'd196608;
        32'd10:  s = 19'd207243;
        32'd11:  s = 19'd217358;
        32'd12:  s = 19'd227023;
        32'd13:  s = 19'd236293;
        32'd14:  s = 19'd245213;
        32'd15:  s = 19'd253820;
        32'd16:  s = 19'd262144;
        default: s = 19'd370728;
      endcase
      return s;
    end
  endfunction

endpackage

### hdl/edtpc_div.sv
`timescale 1ns / 1ps
module edtpc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  edtpc_pkg::div_req_t         req_i,
  input  logic [edtpc_pkg::DivW-1:0]  dividend_i,
  input  logic [edtpc_pkg::DsrW-1:0]  divisor_i,
  output logic                        done_o,
  output logic [edtpc_pkg::DivW-1:0]  quotient_o
);
  import edtpc_pkg::*;

  logic [DivW-1:0] dvd_q, dvd_d, quo_q, quo_d;
  logic [DsrW-1:0] rem_q, rem_d, dsr_q, dsr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DsrW:0]   trial;
  logic [DsrW:0]   diff;

  // One restoring step per cycle, dividend taken from its top bit down.
  assign trial = {rem_q, dvd_q[DivW-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d  = dividend_i;
      quo_d  = '0;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = req_i.iters;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DivW-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = diff[DsrW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = trial[DsrW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start && req_i.iters != '0 |=> busy_q)
    else $error("divider did not start");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a run");
endmodule

### hdl/edt_pacer_codel_drop_top.sv
`timescale 1ns / 1ps
// A packet that passes or drops without a control-law step, or drops at the horizon, runs one
// division; idle pacing runs a second division, and a further division computes the next
// drop time when the control law steps.
// Throughput: one packet at a time; the bit-serial divider (48 or 56 steps) sets the rate
// and a stalled output adds its wait.
// Reset (rst_ni low, asynchronous) clears all pacing and dropper state and loads defaults.
module edt_pacer_codel_drop_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // wire_length[17:0], preset_time[81:18], now_ns[145:82], zero fill
  input  logic [151:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // departure_time[63:0]
  output logic [63:0]  m_axis_tdata,
  // verdict[0], ecn_mark[1]
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [3:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i
);
  import edtpc_pkg::*;

  // Configuration registers.
  logic [33:0] rate_q;
  logic [7:0]  ovh_q;
  logic [10:0] minf_q;
  logic [15:0] idlemin_q;
  logic [39:0] droph_q, target_q, ecnh_q, interval_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q     <= 34'd123750000;
      ovh_q      <= 8'd32;
      minf_q     <= 11'd84;
      idlemin_q  <= 16'd1538;
      droph_q    <= 40'd15000000;
      target_q   <= 40'd10000000;
      ecnh_q     <= 40'd5000000;
      interval_q <= 40'd100000000;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegRate:     rate_q     <= cfg_data_i[33:0];
        RegOverhead: ovh_q      <= cfg_data_i[7:0];
        RegMinFrame: minf_q     <= cfg_data_i[10:0];
        RegIdleMin:  idlemin_q  <= cfg_data_i[15:0];
        RegDropHor:  droph_q    <= cfg_data_i[39:0];
        RegTarget:   target_q   <= cfg_data_i[39:0];
        RegEcnHor:   ecnh_q     <= cfg_data_i[39:0];
        RegInterval: interval_q <= cfg_data_i[39:0];
        default: ;
      endcase
    end
  end

  // Sequencer and working registers.
  state_e      state_q;
  logic [18:0] len_q;
  logic [63:0] tcur_q, now_q, tnext_q, qdelay_q, base_q;
  logic [47:0] prod_q;
  logic        second_q, ok_q;
  logic [63:0] last_q, above_q, ndt_q;
  logic [31:0] cnt_q;
  logic        indrop_q;
  logic        res_verdict_q, res_ecn_q;
  logic [63:0] res_dep_q;
  logic        out_valid_q, out_verdict_q, out_ecn_q;
  logic [63:0] out_dep_q;

  div_req_t        div_req;
  logic [63:0]     div_dividend;
  logic [33:0]     div_divisor;
  logic            div_done;
  logic [63:0]     div_quo;

  logic [18:0] len_in, len_idle;
  logic        out_free;
  logic [63:0] t_sum;
  logic [63:0] int64;

  assign int64    = {24'd0, interval_q};
  assign len_in   = 19'(s_axis_tdata[17:0]) + 19'(ovh_q);
  assign len_idle = (len_q < 19'(idlemin_q)) ? 19'(idlemin_q) : len_q;
  assign out_free = !out_valid_q || m_axis_tready;
  assign t_sum    = last_q + div_quo;
  assign s_axis_tready = (state_q == ST_IDLE);

  // Divider inputs: transmit time or control-law step, pre-aligned to the top bit.
  always_comb begin
    div_req.start = 1'b0;
    div_req.iters = CntW'(48);
    div_dividend  = {prod_q, 16'd0};
    div_divisor   = (rate_q == '0) ? 34'd1 : rate_q;
    if (state_q == ST_DST) begin
      div_req.start = 1'b1;
    end else if (state_q == ST_LAW) begin
      div_req.start = 1'b1;
      div_req.iters = CntW'(56);
      div_dividend  = {interval_q, 24'd0};
      div_divisor   = 34'(sqrt_sh16(cnt_q));
    end
  end

  edtpc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= '0;
      above_q     <= '0;
      ndt_q       <= '0;
      cnt_q       <= '0;
      indrop_q    <= 1'b0;
      second_q    <= 1'b0;
      ok_q        <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            second_q <= 1'b0;
            state_q  <= ST_MUL;
          end
        end
        ST_MUL: state_q <= ST_DST;
        ST_DST: state_q <= ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            if (second_q) begin
              last_q  <= tcur_q + div_quo;
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_CMP;
            end
          end
        end
        ST_CMP: begin
          if (tnext_q <= tcur_q) begin
            second_q <= 1'b1;
            state_q  <= ST_MUL;
          end else begin
            state_q <= ST_CD1;
          end
        end
        ST_CD1: begin
          if (qdelay_q >= 64'(droph_q)) begin
            state_q <= ST_DONE;
          end else begin
            if (qdelay_q < 64'(target_q)) begin
              above_q <= '0;
              ok_q    <= 1'b0;
            end else if (above_q == '0) begin
              above_q <= tnext_q + int64;
              ok_q    <= 1'b0;
            end else begin
              ok_q <= (tnext_q >= above_q);
            end
            state_q <= ST_CD2;
          end
        end
        ST_CD2: begin
          if (indrop_q) begin
            if (!ok_q) begin
              indrop_q <= 1'b0;
              state_q  <= ST_DONE;
            end else if (tnext_q >= ndt_q) begin
              cnt_q   <= cnt_q + 32'd1;
              state_q <= ST_LAW;
            end else begin
              state_q <= ST_DONE;
            end
          end else if (ok_q && (((tnext_q - ndt_q) < int64) ||
                                ((tnext_q - above_q) >= int64))) begin
            indrop_q <= 1'b1;
            if ((tnext_q - ndt_q) < int64) begin
              cnt_q <= (cnt_q > 32'd2) ? cnt_q - 32'd2 : 32'd1;
            end else begin
              cnt_q <= 32'd1;
            end
            state_q <= ST_LAW;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_LAW: state_q <= ST_LDIV;
        ST_LDIV: begin
          if (div_done) begin
            ndt_q   <= base_q + div_quo;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            if (!res_verdict_q) last_q <= res_dep_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Output valid: set when a result is loaded, cleared by its transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload registers and result selection.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        len_q  <= (len_in <= 19'(minf_q)) ? 19'(minf_q) : len_in;
        tcur_q <= (s_axis_tdata[81:18] < s_axis_tdata[145:82]) ?
                  s_axis_tdata[145:82] : s_axis_tdata[81:18];
        now_q  <= s_axis_tdata[145:82];
      end
      ST_MUL: prod_q <= 48'(len_q) * 48'(NsPerSec);
      ST_DIV: begin
        if (div_done) begin
          tnext_q <= t_sum;
          if (second_q) begin
            res_verdict_q <= 1'b0;
            res_ecn_q     <= 1'b0;
            res_dep_q     <= tcur_q + div_quo;
          end
        end
      end
      ST_CMP: begin
        qdelay_q <= tnext_q - now_q;
        len_q    <= len_idle;
      end
      ST_CD1: begin
        res_verdict_q <= 1'b1;
        res_ecn_q     <= 1'b0;
        res_dep_q     <= '0;
      end
      ST_CD2: begin
        base_q <= indrop_q ? ndt_q : tnext_q;
        if (indrop_q ? (!ok_q || tnext_q < ndt_q) :
            !(ok_q && (((tnext_q - ndt_q) < int64) ||
                       ((tnext_q - above_q) >= int64)))) begin
          res_verdict_q <= 1'b0;
          res_ecn_q     <= (qdelay_q >= 64'(ecnh_q));
          res_dep_q     <= tnext_q;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_verdict_q <= res_verdict_q;
          out_ecn_q     <= res_ecn_q;
          out_dep_q     <= res_dep_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_dep_q;
  assign m_axis_tuser  = {out_ecn_q, out_verdict_q};

  a_accept_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> state_q == ST_MUL)
    else $error("accepted packet did not start");
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV || state_q == ST_LDIV))
    else $error("divider finished outside a wait state");
  a_done_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && out_free |=> out_valid_q && state_q == ST_IDLE)
    else $error("result not loaded");
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_verdict_q |-> out_dep_q == '0 && !out_ecn_q)
    else $error("dropped packet carries departure data");
endmodule
